>>> hdl/tss_pkg.sv
// Package with shared widths, types and the lane status struct for the span unit.
package tss_pkg;

	localparam int CoordW = 12;
	localparam int RowW = 9;
	localparam int ColW = 10;
	localparam int ColorW = 32;
	// Numerator 2*(x0*dy+(row-y0)*dx)+dy is below 2^28 in magnitude.
	localparam int NumW = 29;
	localparam int DenW = 14;
	localparam int QuoW = 16;

	typedef struct packed {
		logic                   hit;
		logic signed [QuoW-1:0] col;
	} lane_res_t;

endpackage

>>> hdl/triangle_scanline_span.sv
// Top level of the scanline span unit: lanes, area check, merge and output register.
//  channel | valid    | stall    | fields
//  input   | in_valid | in_stall | vertex_*, scan_row, fill_color
//  output  | out_valid| out_stall| span_*
// One word per cycle while the output is not stalled; the pipeline is one product stage, the 28-stage divider
// in each lane and the output register.
// Reset clears only the stage valid bits.
// The whole pipeline advances when the output register is empty or taken.
module triangle_scanline_span
	import tss_pkg::*;
#(
	parameter int SCREEN_WIDTH = 600,
	parameter int SCREEN_HEIGHT = 400
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [CoordW-1:0] vertex_a_x,
	input  logic signed [CoordW-1:0] vertex_a_y,
	input  logic signed [CoordW-1:0] vertex_b_x,
	input  logic signed [CoordW-1:0] vertex_b_y,
	input  logic signed [CoordW-1:0] vertex_c_x,
	input  logic signed [CoordW-1:0] vertex_c_y,
	input  logic        [RowW-1:0]   scan_row,
	input  logic        [ColorW-1:0] fill_color,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     span_valid,
	output logic        [RowW-1:0]   span_row,
	output logic        [ColW-1:0]   span_left,
	output logic        [ColW-1:0]   span_right,
	output logic        [ColorW-1:0] span_color
);

	localparam int Lat = 1 + NumW - 1;

	logic en;
	assign en = !out_valid || !out_stall;
	assign in_stall = !en;

	lane_res_t lr [3];
	tss_lane u_ab (.clk, .en, .x0(vertex_a_x), .y0(vertex_a_y),
		.x1(vertex_b_x), .y1(vertex_b_y), .row(scan_row), .res(lr[0]));
	tss_lane u_bc (.clk, .en, .x0(vertex_b_x), .y0(vertex_b_y),
		.x1(vertex_c_x), .y1(vertex_c_y), .row(scan_row), .res(lr[1]));
	tss_lane u_ca (.clk, .en, .x0(vertex_c_x), .y0(vertex_c_y),
		.x1(vertex_a_x), .y1(vertex_a_y), .row(scan_row), .res(lr[2]));

	logic signed [CoordW:0] e1x, e1y, e2x, e2y;
	assign e1x = (CoordW+1)'(vertex_b_x) - (CoordW+1)'(vertex_a_x);
	assign e1y = (CoordW+1)'(vertex_b_y) - (CoordW+1)'(vertex_a_y);
	assign e2x = (CoordW+1)'(vertex_c_x) - (CoordW+1)'(vertex_a_x);
	assign e2y = (CoordW+1)'(vertex_c_y) - (CoordW+1)'(vertex_a_y);

	logic signed [26:0] m1_s1, m2_s1;
	logic               ok_q [Lat];
	logic               v_q  [Lat];
	logic [RowW-1:0]    row_q [Lat];
	logic [ColorW-1:0]  col_q [Lat];

	always_ff @(posedge clk) begin
		if (en) begin
			m1_s1 <= 27'(e1x) * 27'(e2y);
			m2_s1 <= 27'(e1y) * 27'(e2x);
			ok_q[0] <= 32'(scan_row) < SCREEN_HEIGHT;
			row_q[0] <= scan_row;
			col_q[0] <= fill_color;
			ok_q[1] <= ok_q[0] && (m1_s1 != m2_s1);
			row_q[1] <= row_q[0];
			col_q[1] <= col_q[0];
			for (int i = 2; i < Lat; i++) begin
				ok_q[i] <= ok_q[i-1];
				row_q[i] <= row_q[i-1];
				col_q[i] <= col_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < Lat; i++) v_q[i] <= 1'b0;
		end else if (en) begin
			v_q[0] <= in_valid;
			for (int i = 1; i < Lat; i++) v_q[i] <= v_q[i-1];
		end
	end

	logic signed [QuoW-1:0] lft, rgt;
	logic any, ok;
	always_comb begin
		any = 1'b0;
		lft = '0;
		rgt = '0;
		for (int i = 0; i < 3; i++) begin
			if (lr[i].hit) begin
				if (!any || lr[i].col < lft) lft = lr[i].col;
				if (!any || lr[i].col > rgt) rgt = lr[i].col;
				any = 1'b1;
			end
		end
		if (lft < 0) lft = '0;
		if (32'(rgt) > SCREEN_WIDTH - 1) rgt = QuoW'(SCREEN_WIDTH - 1);
		ok = ok_q[Lat-1] && any && (lft <= rgt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= v_q[Lat-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			span_valid <= ok;
			span_row <= row_q[Lat-1];
			span_left <= ok ? ColW'(lft) : '0;
			span_right <= ok ? ColW'(rgt) : '0;
			span_color <= ok ? col_q[Lat-1] : '0;
		end
	end

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall)) else $error("stall mismatch");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("word dropped");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !span_valid |-> span_left == 0 && span_color == 0)
		else $error("invalid span not cleared");

endmodule

>>> hdl/tss_div.sv
// Pipelined signed by positive divider, truncating toward zero, one quotient bit per stage.
module tss_div
	import tss_pkg::*;
(
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [NumW-1:0] num,
	input  logic        [DenW-1:0] den,
	input  logic                   tag,
	output logic signed [QuoW-1:0] quo,
	output logic                   tag_out
);

	localparam int Steps = NumW - 1;
	localparam int MagW = NumW - 1;

	logic [MagW-1:0] q0;
	logic            neg0;

	logic [MagW-1:0] rem_s [1:Steps];
	logic [MagW-1:0] q_s   [1:Steps];
	logic [DenW-1:0] den_s [1:Steps];
	logic            neg_s [1:Steps];
	logic            tag_s [1:Steps];

	always_comb begin
		q0 = num[NumW-1] ? MagW'(-num) : MagW'(num);
		neg0 = num[NumW-1];
	end

	for (genvar i = 0; i < Steps; i++) begin : g_step
		logic [MagW-1:0] rem_c;
		logic [MagW-1:0] q_c;
		logic [DenW-1:0] den_c;
		logic            neg_c;
		logic            tag_c;
		logic [MagW:0] trial;
		logic [MagW-1:0] rem_n;
		logic [MagW-1:0] q_n;
		if (i == 0) begin : g_in
			assign rem_c = '0;
			assign q_c = q0;
			assign den_c = den;
			assign neg_c = neg0;
			assign tag_c = tag;
		end else begin : g_mid
			assign rem_c = rem_s[i];
			assign q_c = q_s[i];
			assign den_c = den_s[i];
			assign neg_c = neg_s[i];
			assign tag_c = tag_s[i];
		end
		always_comb begin
			trial = {rem_c, q_c[MagW-1]} - {(MagW+1-DenW)'(0), den_c};
			if (!trial[MagW]) begin
				rem_n = trial[MagW-1:0];
				q_n = {q_c[MagW-2:0], 1'b1};
			end else begin
				rem_n = {rem_c[MagW-2:0], q_c[MagW-1]};
				q_n = {q_c[MagW-2:0], 1'b0};
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= rem_n;
				q_s[i+1] <= q_n;
				den_s[i+1] <= den_c;
				neg_s[i+1] <= neg_c;
				tag_s[i+1] <= tag_c;
			end
		end
	end

	logic [MagW-1:0] qm;
	assign qm = q_s[Steps];
	assign quo = neg_s[Steps] ? -QuoW'(qm) : QuoW'(qm);
	assign tag_out = tag_s[Steps];

endmodule

>>> hdl/tss_lane.sv
// One edge lane: crossing test, numerator and denominator, then the divider.
module tss_lane
	import tss_pkg::*;
(
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [CoordW-1:0] x0,
	input  logic signed [CoordW-1:0] y0,
	input  logic signed [CoordW-1:0] x1,
	input  logic signed [CoordW-1:0] y1,
	input  logic        [RowW-1:0]   row,
	output lane_res_t                res
);

	logic signed [CoordW:0] dy, dx, ry, ry2;
	logic signed [CoordW:0] lo, hi;
	logic signed [25:0] p1_s1, p2_s1;
	logic signed [CoordW:0] dy_s1;
	logic hit_s1;

	always_comb begin
		dy = (CoordW+1)'(y1) - (CoordW+1)'(y0);
		dx = (CoordW+1)'(x1) - (CoordW+1)'(x0);
		ry = $signed({1'b0, {(CoordW-RowW){1'b0}}, row}) - (CoordW+1)'(y0);
		lo = (y0 < y1) ? (CoordW+1)'(y0) : (CoordW+1)'(y1);
		hi = (y0 < y1) ? (CoordW+1)'(y1) : (CoordW+1)'(y0);
		ry2 = $signed({1'b0, {(CoordW-RowW){1'b0}}, row});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s1 <= 26'(x0) * 26'(dy);
			p2_s1 <= 26'(ry) * 26'(dx);
			dy_s1 <= dy;
			hit_s1 <= (dy != 0) && (ry2 >= lo) && (ry2 <= hi);
		end
	end

	logic signed [NumW-1:0] num;
	logic [DenW-1:0] den;
	always_comb begin
		num = NumW'(2 * (NumW'(p1_s1) + NumW'(p2_s1))) + NumW'(dy_s1);
		den = dy_s1[CoordW] ? DenW'(-2 * 14'(dy_s1)) : DenW'(2 * 14'(dy_s1));
		if (dy_s1[CoordW]) num = -num;
	end

	tss_div u_div (
		.clk(clk), .en(en), .num(num), .den(den), .tag(hit_s1),
		.quo(res.col), .tag_out(res.hit)
	);

endmodule

>>> verif/tss_span_checker.sv
// Checker that predicts each span from the input words and compares the output words.
module tss_span_checker
	import tss_pkg::*;
(
	input  logic                     clk,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic signed [CoordW-1:0] vertex_a_x,
	input  logic signed [CoordW-1:0] vertex_a_y,
	input  logic signed [CoordW-1:0] vertex_b_x,
	input  logic signed [CoordW-1:0] vertex_b_y,
	input  logic signed [CoordW-1:0] vertex_c_x,
	input  logic signed [CoordW-1:0] vertex_c_y,
	input  logic        [RowW-1:0]   scan_row,
	input  logic        [ColorW-1:0] fill_color,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic                     span_valid,
	input  logic        [RowW-1:0]   span_row,
	input  logic        [ColW-1:0]   span_left,
	input  logic        [ColW-1:0]   span_right,
	input  logic        [ColorW-1:0] span_color,
	output int                       fail_count,
	output int                       pending,
	output int                       spans_seen,
	output int                       valid_spans
);

	localparam int ScreenW = 600;
	localparam int ScreenH = 400;

	typedef struct packed {
		logic              valid;
		logic [RowW-1:0]   row;
		logic [ColW-1:0]   left;
		logic [ColW-1:0]   right;
		logic [ColorW-1:0] color;
	} span_t;

	span_t expected_spans[$];

	initial begin
		fail_count = 0;
		spans_seen = 0;
		valid_spans = 0;
	end

	assign pending = expected_spans.size();

	function automatic bit edge_column(longint px, longint py, longint qx, longint qy,
			longint row, output longint col);
		longint dy, dx, num, den;
		dy = qy - py;
		dx = qx - px;
		col = 0;
		if (dy == 0) return 0;
		if (row < (py < qy ? py : qy) || row > (py < qy ? qy : py)) return 0;
		num = 2 * (px * dy + (row - py) * dx) + dy;
		den = 2 * dy;
		if (den < 0) begin
			num = -num;
			den = -den;
		end
		col = num / den;
		return 1;
	endfunction

	function automatic span_t predict_span(longint ax, longint ay, longint bx, longint by,
			longint cx, longint cy, longint row, logic [ColorW-1:0] color);
		span_t s;
		longint area, lo, hi, x;
		longint px[3], py[3];
		bit any;
		s = '0;
		s.row = row[RowW-1:0];
		any = 0;
		lo = 0;
		hi = 0;
		px = '{ax, bx, cx};
		py = '{ay, by, cy};
		area = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
		if (area != 0 && row < ScreenH) begin
			for (int e = 0; e < 3; e++) begin
				if (edge_column(px[e], py[e], px[(e+1)%3], py[(e+1)%3], row, x)) begin
					if (!any || x < lo) lo = x;
					if (!any || x > hi) hi = x;
					any = 1;
				end
			end
			if (any) begin
				if (lo < 0) lo = 0;
				if (hi > ScreenW - 1) hi = ScreenW - 1;
				if (lo <= hi) begin
					s.valid = 1;
					s.left = lo[ColW-1:0];
					s.right = hi[ColW-1:0];
					s.color = color;
				end
			end
		end
		return s;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk) begin
		span_t want;
		if (in_valid && !in_stall)
			expected_spans.push_back(predict_span(vertex_a_x, vertex_a_y, vertex_b_x,
				vertex_b_y, vertex_c_x, vertex_c_y, scan_row, fill_color));
		if (out_valid && !out_stall) begin
			spans_seen++;
			if (span_valid) valid_spans++;
			if (expected_spans.size() == 0) begin
				report_mismatch("unexpected word, row", span_row, -1);
			end else begin
				want = expected_spans.pop_front();
				if (span_valid !== want.valid) report_mismatch("span_valid", span_valid, want.valid);
				if (span_row !== want.row) report_mismatch("span_row", span_row, want.row);
				if (span_left !== want.left) report_mismatch("span_left", span_left, want.left);
				if (span_right !== want.right)
					report_mismatch("span_right", span_right, want.right);
				if (span_color !== want.color)
					report_mismatch("span_color", span_color, want.color);
			end
		end
	end

endmodule

>>> verif/tb_triangle_scanline_span.sv
// Testbench top that drives triangle words into the span unit and gives the verdict.
module tb_triangle_scanline_span
	import tss_pkg::*;
();

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [CoordW-1:0] vertex_a_x = 0, vertex_a_y = 0, vertex_b_x = 0;
	logic signed [CoordW-1:0] vertex_b_y = 0, vertex_c_x = 0, vertex_c_y = 0;
	logic [RowW-1:0] scan_row = 0;
	logic [ColorW-1:0] fill_color = 0;
	logic out_valid;
	logic out_stall = 0;
	logic span_valid;
	logic [RowW-1:0] span_row;
	logic [ColW-1:0] span_left, span_right;
	logic [ColorW-1:0] span_color;
	int fail_count, pending, spans_seen, valid_spans;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	always #5 clk = ~clk;

	triangle_scanline_span dut (.*);

	tss_span_checker checker_i (.*);

	always @(posedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

	task automatic send_triangle(int ax, int ay, int bx, int by, int cx, int cy, int row,
			logic [ColorW-1:0] color);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		vertex_a_x <= CoordW'(ax);
		vertex_a_y <= CoordW'(ay);
		vertex_b_x <= CoordW'(bx);
		vertex_b_y <= CoordW'(by);
		vertex_c_x <= CoordW'(cx);
		vertex_c_y <= CoordW'(cy);
		scan_row <= RowW'(row);
		fill_color <= color;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_random(int span);
		int base, row;
		base = $urandom_range(1) ? 0 : $urandom_range(4095) - 2048;
		row = ($urandom_range(19) == 0) ? $urandom_range(511) : $urandom_range(399);
		if ($urandom_range(9) < 7)
			send_triangle(base + $urandom_range(span), row - $urandom_range(span / 2),
				base + $urandom_range(span), row + $urandom_range(span / 2),
				base + $urandom_range(span), row - span / 4 + $urandom_range(span / 2),
				row, $urandom);
		else
			send_triangle($urandom_range(4095) - 2048, $urandom_range(4095) - 2048,
				$urandom_range(4095) - 2048, $urandom_range(4095) - 2048,
				$urandom_range(4095) - 2048, $urandom_range(4095) - 2048,
				$urandom_range(511), $urandom);
	endtask

	initial begin
		#2000000;
		$display("** triangle_scanline_span: FAILED **");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_triangle(10, 10, 100, 50, 20, 90, 40, 32'hFF00FF00);
		send_triangle(0, 0, 10, 10, 20, 20, 5, 32'hFFFFFFFF);
		send_triangle(10, 10, 100, 50, 20, 90, 400, 32'h12345678);
		send_triangle(10, 10, 100, 50, 20, 90, 511, 32'h12345678);
		send_triangle(10, 10, 100, 50, 20, 90, 200, 32'h1);
		send_triangle(-100, 0, -50, 100, -80, 50, 30, 32'h2);
		send_triangle(700, 0, 900, 100, 800, 50, 30, 32'h3);
		send_triangle(-2048, -2048, 2047, 0, -2048, 2047, 0, 32'hFFFFFFFF);
		send_triangle(2047, 2047, -2048, 2047, 2047, -2048, 399, 32'h80000001);
		send_triangle(0, 0, 599, 0, 300, 300, 0, 32'hA5A5A5A5);
		send_triangle(0, 100, 599, 100, 0, 300, 100, 32'h5A5A5A5A);
		send_triangle(5, 7, 6, 8, 4, 9, 8, 32'h0);
		send_triangle(-1, 0, 3, 3, -3, 3, 1, 32'h7FFFFFFF);
		send_triangle(-2048, 0, -2048, 399, -1, 200, 200, 32'hDEADBEEF);
		send_triangle(2047, 0, 2047, 399, 601, 200, 200, 32'hCAFEF00D);
		send_triangle(0, 0, 0, 0, 0, 0, 0, 32'h0);
		send_triangle(1, 2, 3, 1, 2, 5, 2, 32'hFFFF0000);
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		send_idle_pct = 8;
		recv_idle_pct = 49;
		repeat (310) send_random($urandom_range(3) == 0 ? 2000 : 400);
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		send_idle_pct = 49;
		recv_idle_pct = 8;
		repeat (310) send_random($urandom_range(3) == 0 ? 2000 : 400);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (330) send_random($urandom_range(3) == 0 ? 2000 : 40);
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("Sent %0d triangle words under mixed stall patterns; %0d spans returned.",
			spans_seen, spans_seen);
		$display("Of those, %0d were fillable spans.", valid_spans);
		if (fail_count == 0) begin
			$display("** triangle_scanline_span: PASSED **");
		end else begin
			$display("** triangle_scanline_span: FAILED **");
		end
		$finish;
	end

endmodule
